FILE: rtl/core/ptt_pkg.sv
// Shared types and constants for the pending transaction tracker.
// Depends on nothing; used by ptt_ram users and the top level.
package ptt_pkg;

  // Table geometry
  localparam int TBL_DEPTH = 16;
  localparam int IDX_W     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int CNT_W     = $clog2(TBL_DEPTH + 1);

  // Stream field widths
  localparam int OP_W        = 2;
  localparam int PID_W       = 16;
  localparam int MID_W       = 16;
  localparam int CMD_W       = 8;
  localparam int STATUS_W    = 3;
  localparam int SLOT_W      = 4;
  localparam int COUNT_W     = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // Event kinds
  localparam logic [OP_W-1:0] OP_REQUEST  = 2'd0;
  localparam logic [OP_W-1:0] OP_RESPONSE = 2'd1;
  localparam logic [OP_W-1:0] OP_CANCEL   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_ADDED         = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED       = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_CLOSED        = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_REPLY_CANCEL  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NO_MATCH      = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_CANCELLED     = 3'd5;
  localparam logic [STATUS_W-1:0] STATUS_ALREADY_CANCL = 3'd6;

  // One table entry
  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [MID_W-1:0] mid;
    logic [CMD_W-1:0] cmd;
    logic             dead;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_COMPACT,
    S_APPEND,
    S_FINISH
  } state_t;

endpackage

FILE: rtl/core/pending_transaction_tracker.sv
// Pending transaction tracker: ordered table of outstanding transactions in one RAM.
// Depends on ptt_pkg and ptt_ram.
//
// Usage: each input transaction (in_tuser = event kind, in_tdata = pid/mid/cmd)
// yields exactly one result transaction on the out_ channel carrying status,
// matched or added slot, and the held and live entry counts after the event.
// Requests append an entry, compacting cancelled entries out first when the
// table is full; responses search in order and close the first match if it is live,
// shifting later entries down; cancels mark the first pid/mid match cancelled.
// Operation: one event is worked at a time, walking the table RAM with one read
// issued per cycle against its registered read data. A search walks the held
// entries in order, a close then shifts the later entries down, and a compaction
// walks every held entry; requests pass through append, and every event through
// finish and back to idle.
// The longest events, set by the single RAM read port, are a full-table
// compaction before an append and a close near the front.
// Reset clears the counts and the sequencer; table contents are not cleared
// since only entries below the held count are ever read.
// The result sits in an output register; a new event is taken while it waits,
// and the sequencer holds its finished result until out_tready frees the register.
module pending_transaction_tracker
  import ptt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [OP_W-1:0]        in_tuser,   // [1:0] op
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] proc_id, [31:16] mux_id, [39:32] command
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [2:0] status, [6:3] slot,
                                             // [11:7] held_count, [16:12] live_count
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]    held_r, held_nxt;
  logic [CNT_W-1:0]    live_r, live_nxt;
  logic [CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]    wr_idx_r, wr_idx_nxt;
  logic                pend_r, pend_nxt;
  logic [IDX_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [PID_W-1:0]    pid_r, pid_nxt;
  logic [MID_W-1:0]    mid_r, mid_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [IDX_W-1:0]    res_slot_r, res_slot_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  entry_t             rd_ent, new_ent;

  logic in_acc, issue_more, walk_done, hit, full, out_free;

  ptt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TBL_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Shared status terms
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign rd_ent     = entry_t'(ram_rdata);
  assign issue_more = (rd_idx_r < held_r);
  assign walk_done  = !issue_more && !pend_r;
  assign full       = (held_r >= CNT_W'(TBL_DEPTH));
  assign out_free   = !out_valid_r || out_tready;
  assign hit        = pend_r && (rd_ent.pid == pid_r) && (rd_ent.mid == mid_r) &&
                      ((op_r != OP_RESPONSE) || (rd_ent.cmd == cmd_r));
  assign ram_raddr  = rd_idx_r[IDX_W-1:0];

  always_comb begin
    new_ent      = '0;
    new_ent.pid  = pid_r;
    new_ent.mid  = mid_r;
    new_ent.cmd  = cmd_r;
    new_ent.dead = 1'b0;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            OP_REQUEST:  state_nxt = (full && (held_r > live_r)) ? S_COMPACT : S_APPEND;
            OP_RESPONSE: state_nxt = S_SEARCH;
            OP_CANCEL:   state_nxt = S_SEARCH;
            default:     state_nxt = S_FINISH;
          endcase
        end
      end
      S_SEARCH: begin
        if (hit) begin
          state_nxt = ((op_r == OP_RESPONSE) && !rd_ent.dead) ? S_SHIFT : S_FINISH;
        end else if (walk_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_SHIFT: begin
        if (walk_done) state_nxt = S_FINISH;
      end
      S_COMPACT: begin
        if (walk_done) state_nxt = S_APPEND;
      end
      S_APPEND: state_nxt = S_FINISH;
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    held_nxt       = held_r;
    live_nxt       = live_r;
    rd_idx_nxt     = rd_idx_r;
    wr_idx_nxt     = wr_idx_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    op_nxt         = op_r;
    pid_nxt        = pid_r;
    mid_nxt        = mid_r;
    cmd_nxt        = cmd_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = pend_idx_r;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt         = in_tuser;
          pid_nxt        = in_tdata[PID_W-1:0];
          mid_nxt        = in_tdata[PID_W +: MID_W];
          cmd_nxt        = in_tdata[PID_W+MID_W +: CMD_W];
          rd_idx_nxt     = '0;
          wr_idx_nxt     = '0;
          res_status_nxt = STATUS_NO_MATCH;
          res_slot_nxt   = '0;
        end
      end

      // In-order walk, first match wins
      S_SEARCH: begin
        ram_re = issue_more && !hit;
        if (ram_re) begin
          rd_idx_nxt   = rd_idx_r + CNT_W'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_idx_r[IDX_W-1:0];
        end
        if (hit) begin
          res_slot_nxt = pend_idx_r;
          if (rd_ent.dead) begin
            res_status_nxt = (op_r == OP_RESPONSE) ? STATUS_REPLY_CANCEL
                                                   : STATUS_ALREADY_CANCL;
          end else if (op_r == OP_RESPONSE) begin
            res_status_nxt = STATUS_CLOSED;
            rd_idx_nxt     = CNT_W'(pend_idx_r) + CNT_W'(1);
          end else begin
            // Cancel: mark the entry in place
            res_status_nxt = STATUS_CANCELLED;
            ram_we         = 1'b1;
            ram_waddr      = pend_idx_r;
            ram_wdata      = {rd_ent.pid, rd_ent.mid, rd_ent.cmd, 1'b1};
            if (live_r != '0) live_nxt = live_r - CNT_W'(1);
          end
        end
      end

      // Move later entries down one place
      S_SHIFT: begin
        ram_re = issue_more;
        if (ram_re) begin
          rd_idx_nxt   = rd_idx_r + CNT_W'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_idx_r[IDX_W-1:0];
        end
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx_r - IDX_W'(1);
          ram_wdata = ram_rdata;
        end
        if (walk_done) begin
          held_nxt = held_r - CNT_W'(1);
          if (live_r != '0) live_nxt = live_r - CNT_W'(1);
        end
      end

      // Squeeze cancelled entries out, keeping order
      S_COMPACT: begin
        ram_re = issue_more;
        if (ram_re) begin
          rd_idx_nxt   = rd_idx_r + CNT_W'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_idx_r[IDX_W-1:0];
        end
        if (pend_r && !rd_ent.dead) begin
          ram_we     = 1'b1;
          ram_waddr  = wr_idx_r[IDX_W-1:0];
          ram_wdata  = ram_rdata;
          wr_idx_nxt = wr_idx_r + CNT_W'(1);
        end
        if (walk_done) held_nxt = wr_idx_r;
      end

      S_APPEND: begin
        if (full) begin
          res_status_nxt = STATUS_DROPPED;
          res_slot_nxt   = '0;
        end else begin
          ram_we         = 1'b1;
          ram_waddr      = held_r[IDX_W-1:0];
          ram_wdata      = new_ent;
          res_status_nxt = STATUS_ADDED;
          res_slot_nxt   = held_r[IDX_W-1:0];
          held_nxt       = held_r + CNT_W'(1);
          live_nxt       = live_r + CNT_W'(1);
        end
      end

      // Load the output register once it is free
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({COUNT_W'(live_r), COUNT_W'(held_r),
                                        SLOT_W'(res_slot_r), res_status_r});
        end
      end

      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      live_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      live_r      <= live_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    wr_idx_r     <= wr_idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    op_r         <= op_nxt;
    pid_r        <= pid_nxt;
    mid_r        <= mid_nxt;
    cmd_r        <= cmd_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/core/ptt_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
